// ===== design/hibe_pkg.sv =====
// ----------------------------------------------------------------------------
// hibe_pkg
// Shared constants, codes and keyword table of the HTTP image body extractor.
// ----------------------------------------------------------------------------
package hibe_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int MAX_SLOTS   = 16;
  localparam int SLOT_W      = 5;
  localparam int TSLOT_W     = 4;
  localparam int CNT_W       = $clog2(LENGTH_BITS + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;

  // parse phases, as seen on the output
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_WRITE  = 3'd2;
  localparam logic [2:0] PH_DONE   = 3'd3;
  localparam logic [2:0] PH_ERROR  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SLOT = 2'd2;

  localparam logic [4:0] KW_LEN   = 5'd14;
  localparam logic [4:0] KW_FOUND = 5'd16;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  // "Content-Length"
  function automatic logic [7:0] kw_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6f; // o
      4'd2:    c = 8'h6e; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6e; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2d; // -
      4'd8:    c = 8'h4c; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6e; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== design/hibe_div.sv =====
// ----------------------------------------------------------------------------
// hibe_div
// Bit-serial restoring divider: length by slot count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module hibe_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [hibe_pkg::LENGTH_BITS-1:0] dividend,
  input  logic [hibe_pkg::SLOT_W-1:0]      divisor,
  output logic                             done,
  output logic [hibe_pkg::LENGTH_BITS-1:0] quotient
);
  import hibe_pkg::*;

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t                dst;
  logic [CNT_W-1:0]       cnt;
  logic [SLOT_W-1:0]      rem;
  logic [SLOT_W-1:0]      dvs;
  logic [LENGTH_BITS-1:0] quo;
  logic [SLOT_W:0]        trial;
  logic                   fits;
  logic [SLOT_W-1:0]      rem_next;

  // remainder stays below the divisor, so it fits in SLOT_W bits
  assign trial    = {rem, quo[LENGTH_BITS-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign rem_next = fits ? SLOT_W'(trial - {1'b0, dvs}) : trial[SLOT_W-1:0];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst  <= D_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (dst)
        D_IDLE: begin
          if (start) begin
            quo <= dividend;
            dvs <= divisor;
            rem <= '0;
            cnt <= CNT_W'(LENGTH_BITS);
            dst <= D_RUN;
          end
        end
        D_RUN: begin
          quo <= {quo[LENGTH_BITS-2:0], fits};
          rem <= rem_next;
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            dst  <= D_IDLE;
            done <= 1'b1;
          end
        end
        default: dst <= D_IDLE;
      endcase
    end
  end

endmodule

// ===== design/http_image_body_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// http_image_body_extractor_unit
// Scans an HTTP response byte stream for Content-Length, then flags the body
// bytes of the selected image slot.
// ----------------------------------------------------------------------------
// Ordinary bytes: the output item appears in the cycle after input accept.
// Throughput: one byte per cycle while m_tready does not hold the output. With
// split_mode 0 the byte that ends the header stalls the input while the divider
// is loaded, runs 32 bit-serial steps, the quotient is taken and the offset is set.
// Reset: synchronous; clears parse state, registers return to split_mode 1,
// slot_count 2, target_slot 0.
module http_image_body_extractor_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,  // [7:0] data_byte
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [7:0]                          m_tdata,  // [7:0] out_byte
  // [0] write_valid, [3:1] phase, [4] header_done
  output logic [4:0]                          m_tuser,
  input  logic                                cfg_we,
  input  logic [hibe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hibe_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import hibe_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_MUL} state_t;

  state_t                 st;
  logic                   split_mode;
  logic [SLOT_W-1:0]      slot_count;
  logic [TSLOT_W-1:0]     target_slot;

  logic [2:0]             parse_phase;
  logic [4:0]             keyword_match_index;
  logic                   digits_active;
  logic [LENGTH_BITS-1:0] content_length;
  logic [1:0]             line_byte_count;
  logic [LENGTH_BITS-1:0] body_byte_count;
  logic [LENGTH_BITS-1:0] image_size;
  logic [LENGTH_BITS-1:0] image_offset;

  logic [2:0]             parse_phase_next;
  logic [4:0]             keyword_match_index_next;
  logic                   digits_active_next;
  logic [LENGTH_BITS-1:0] content_length_next;
  logic [1:0]             line_byte_count_next;
  logic [LENGTH_BITS-1:0] body_byte_count_next;
  logic [LENGTH_BITS-1:0] image_size_next;
  logic [LENGTH_BITS-1:0] image_offset_next;
  logic                   wv;
  logic                   hd;
  logic                   go_div;

  logic                   accept;
  logic [7:0]             b;
  logic                   is_digit;
  logic [LENGTH_BITS+3:0] acc_wide;
  logic [LENGTH_BITS-1:0] acc_sat;
  logic [LENGTH_BITS-1:0] bbc_inc;
  logic [SLOT_W-1:0]      n_eff;

  logic                   div_start;
  logic                   div_done;
  logic [LENGTH_BITS-1:0] div_quo;

  logic [LENGTH_BITS+3:0] prod;
  logic [LENGTH_BITS-1:0] off_sat;
  logic [2:0]             mul_phase;

  assign s_tready = (st == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign b        = s_tdata;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);

  // length * 10 + digit, saturating
  assign acc_wide = {1'b0, content_length, 3'b000} + {3'b000, content_length, 1'b0}
                  + {{LENGTH_BITS{1'b0}}, b[3:0]};
  assign acc_sat  = (acc_wide[LENGTH_BITS+3:LENGTH_BITS] != 4'd0)
                  ? LEN_MAX : acc_wide[LENGTH_BITS-1:0];
  assign bbc_inc  = body_byte_count + LENGTH_BITS'(1);

  always_comb begin
    if (slot_count == '0) begin
      n_eff = SLOT_W'(1);
    end else if (slot_count > SLOT_W'(MAX_SLOTS)) begin
      n_eff = SLOT_W'(MAX_SLOTS);
    end else begin
      n_eff = slot_count;
    end
  end

  // per-byte parse step
  always_comb begin
    parse_phase_next         = parse_phase;
    keyword_match_index_next = keyword_match_index;
    digits_active_next       = digits_active;
    content_length_next      = content_length;
    line_byte_count_next     = line_byte_count;
    body_byte_count_next     = body_byte_count;
    image_size_next          = image_size;
    image_offset_next        = image_offset;
    wv                       = 1'b0;
    hd                       = 1'b0;
    go_div                   = 1'b0;
    case (parse_phase)
      PH_HEADER: begin
        if (digits_active) begin
          if (is_digit) begin
            content_length_next = acc_sat;
          end else begin
            digits_active_next = 1'b0;
          end
        end else if (keyword_match_index < KW_LEN) begin
          if (b == kw_char(keyword_match_index[3:0])) begin
            keyword_match_index_next = keyword_match_index + 5'd1;
          end else begin
            keyword_match_index_next = (b == kw_char(4'd0)) ? 5'd1 : 5'd0;
          end
        end else if (keyword_match_index < KW_FOUND) begin
          keyword_match_index_next = keyword_match_index + 5'd1;
          if (keyword_match_index + 5'd1 == KW_FOUND) begin
            digits_active_next = 1'b1;
          end
        end

        if (b == CH_LF) begin
          if (line_byte_count == 2'd1) begin
            // empty line: header ends here
            hd                   = 1'b1;
            digits_active_next   = 1'b0;
            body_byte_count_next = '0;
            if (content_length_next == '0) begin
              parse_phase_next = PH_ERROR;
            end else if (!split_mode) begin
              go_div = 1'b1;
            end else begin
              image_size_next   = content_length_next;
              image_offset_next = '0;
              parse_phase_next  = PH_WRITE;
            end
          end
          line_byte_count_next = 2'd0;
        end else if (line_byte_count == 2'd0 && b == CH_CR) begin
          line_byte_count_next = 2'd1;
        end else begin
          line_byte_count_next = 2'd2;
        end
      end
      PH_SKIP: begin
        body_byte_count_next = bbc_inc;
        if (bbc_inc >= image_offset) begin
          body_byte_count_next = '0;
          parse_phase_next     = PH_WRITE;
        end
      end
      PH_WRITE: begin
        wv                   = 1'b1;
        body_byte_count_next = bbc_inc;
        if (bbc_inc >= image_size) begin
          parse_phase_next = PH_DONE;
        end
      end
      default: ;
    endcase
  end

  assign div_start = accept && go_div;

  hibe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (content_length_next),
    .divisor  (n_eff),
    .done     (div_done),
    .quotient (div_quo)
  );

  // slot offset = size * target_slot, saturating
  assign prod    = image_size * {{LENGTH_BITS{1'b0}}, target_slot};
  assign off_sat = (prod[LENGTH_BITS+3:LENGTH_BITS] != 4'd0)
                 ? LEN_MAX : prod[LENGTH_BITS-1:0];

  always_comb begin
    if (image_size == '0) begin
      mul_phase = PH_DONE;
    end else if (off_sat == '0) begin
      mul_phase = PH_WRITE;
    end else begin
      mul_phase = PH_SKIP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st                  <= ST_IDLE;
      m_tvalid            <= 1'b0;
      split_mode          <= 1'b1;
      slot_count          <= SLOT_W'(2);
      target_slot         <= '0;
      parse_phase         <= PH_HEADER;
      keyword_match_index <= '0;
      digits_active       <= 1'b0;
      content_length      <= '0;
      line_byte_count     <= '0;
      body_byte_count     <= '0;
      image_size          <= '0;
      image_offset        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SPLIT_MODE:  split_mode  <= cfg_data[0];
          REG_SLOT_COUNT:  slot_count  <= cfg_data[SLOT_W-1:0];
          REG_TARGET_SLOT: target_slot <= cfg_data[TSLOT_W-1:0];
          default: ;
        endcase
      end

      // an accepted input sets the output valid itself
      if (m_tvalid && m_tready && !accept) begin
        m_tvalid <= 1'b0;
      end

      unique case (st)
        ST_IDLE: begin
          if (accept) begin
            parse_phase         <= parse_phase_next;
            keyword_match_index <= keyword_match_index_next;
            digits_active       <= digits_active_next;
            content_length      <= content_length_next;
            line_byte_count     <= line_byte_count_next;
            body_byte_count     <= body_byte_count_next;
            image_size          <= image_size_next;
            image_offset        <= image_offset_next;
            m_tdata             <= b;
            m_tuser             <= {hd, parse_phase_next, wv};
            m_tvalid            <= !go_div;
            if (go_div) begin
              st <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            image_size <= div_quo;
            st         <= ST_MUL;
          end
        end
        ST_MUL: begin
          image_offset <= off_sat;
          parse_phase  <= mul_phase;
          m_tuser[3:1] <= mul_phase;
          m_tvalid     <= 1'b1;
          st           <= ST_IDLE;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (st != ST_IDLE) |-> !s_tready)
    else $error("input taken while divider sequence runs");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (st == ST_DIV))
    else $error("divider finished outside the divide step");

  a_hdr_done_phase: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[4]) |-> (m_tuser[3:1] != PH_HEADER))
    else $error("header end reported while still in header phase");

  a_error_sticks: assert property (@(posedge clk) disable iff (rst)
    (parse_phase == PH_ERROR) |=> (parse_phase == PH_ERROR))
    else $error("left error phase without reset");

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HTTP image body extractor. It streams a
// response header of random lines with at most one Content-Length field, then the
// body, and checks every output item against an in-bench parser model.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hibe_pkg::*;

  localparam int ITEM_TARGET = 1400;
  localparam int DRAIN_PAD   = 40;   // covers the divide at header end
  localparam int IDLE_LIMIT  = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AT     = 150;

  typedef struct packed {
    logic [7:0] data;
    logic       wr;
    logic [2:0] phase;
    logic       hdr_end;
  } marked_byte_t;

  class body_board;
    logic        split_mode;
    logic [4:0]  slot_count;
    logic [3:0]  target_slot;

    logic [2:0]  phase;
    logic [4:0]  tag_idx;
    logic        digits_on;
    logic [31:0] length;
    logic [1:0]  line_pos;
    logic [31:0] body_cnt;
    logic [31:0] img_size;
    logic [31:0] img_off;

    string        length_tag;
    marked_byte_t marked_q[$];
    int           errors;
    int           results;

    function new();
      length_tag  = "Content-Length";
      split_mode  = 1'b1;
      slot_count  = 5'd2;
      target_slot = 4'd0;
      phase       = PH_HEADER;
      tag_idx     = '0;
      digits_on   = 1'b0;
      length      = '0;
      line_pos    = '0;
      body_cnt    = '0;
      img_size    = '0;
      img_off     = '0;
      errors      = 0;
      results     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SPLIT_MODE:  split_mode  = val[0];
        REG_SLOT_COUNT:  slot_count  = val[4:0];
        REG_TARGET_SLOT: target_slot = val[3:0];
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] b);
      logic [63:0]  acc;
      logic [31:0]  n;
      marked_byte_t r;
      r = '{data: b, wr: 1'b0, phase: PH_HEADER, hdr_end: 1'b0};
      case (phase)
        PH_HEADER: begin
          // keyword search, two skipped bytes, then digits up to a non-digit
          if (digits_on) begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
              acc = 64'(length) * 64'd10 + 64'(b - CH_ZERO);
              length = (acc > 64'(LEN_MAX)) ? LEN_MAX : acc[31:0];
            end else begin
              digits_on = 1'b0;
            end
          end else if (tag_idx < KW_LEN) begin
            if (b == length_tag[tag_idx])
              tag_idx++;
            else
              tag_idx = (b == length_tag[0]) ? 5'd1 : 5'd0;
          end else if (tag_idx < KW_FOUND) begin
            tag_idx++;
            if (tag_idx == KW_FOUND)
              digits_on = 1'b1;
          end

          if (b == CH_LF) begin
            if (line_pos == 2'd1) begin
              r.hdr_end = 1'b1;
              n = (slot_count == 0) ? 32'd1 :
                  (slot_count > MAX_SLOTS) ? 32'(MAX_SLOTS) : 32'(slot_count);
              digits_on = 1'b0;
              if (length == 0) begin
                phase = PH_ERROR;
              end else begin
                if (!split_mode) begin
                  img_size = length / n;
                  acc = 64'(img_size) * 64'(target_slot);
                  img_off = (acc > 64'(LEN_MAX)) ? LEN_MAX : acc[31:0];
                end else begin
                  img_size = length;
                  img_off  = '0;
                end
                body_cnt = '0;
                if (img_size == 0)
                  phase = PH_DONE;
                else if (img_off == 0)
                  phase = PH_WRITE;
                else
                  phase = PH_SKIP;
              end
            end
            line_pos = 2'd0;
          end else if (line_pos == 2'd0 && b == CH_CR) begin
            line_pos = 2'd1;
          end else begin
            line_pos = 2'd2;
          end
        end
        PH_SKIP: begin
          body_cnt++;
          if (body_cnt >= img_off) begin
            body_cnt = '0;
            phase = PH_WRITE;
          end
        end
        PH_WRITE: begin
          r.wr = 1'b1;
          body_cnt++;
          if (body_cnt >= img_size)
            phase = PH_DONE;
        end
        default: ;
      endcase
      r.phase = phase;
      marked_q.push_back(r);
    endfunction

    task report_mismatch(string what, int idx, logic [31:0] want, logic [31:0] got);
      $display("MISMATCH item %0d %s: expected 0x%0h got 0x%0h", idx, what, want, got);
      errors++;
    endtask

    task check_marked(logic [7:0] data, logic [4:0] user);
      marked_byte_t e;
      results++;
      if (marked_q.size() == 0) begin
        report_mismatch("item with nothing expected", results, 0, data);
        return;
      end
      e = marked_q.pop_front();
      if (data !== e.data)
        report_mismatch("out_byte", results, e.data, data);
      if (user[0] !== e.wr)
        report_mismatch("write_valid", results, e.wr, user[0]);
      if (user[3:1] !== e.phase)
        report_mismatch("phase", results, e.phase, user[3:1]);
      if (user[4] !== e.hdr_end)
        report_mismatch("header_done", results, e.hdr_end, user[4]);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [7:0]            m_tdata;
  logic [4:0]            m_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  body_board  board;
  int         burst_left;
  int         sent_count;
  logic [7:0] prev_byte;
  int         idle_cycles = 0;

  http_image_body_extractor_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // input note first, so a same-edge result always finds its expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        board.take_byte(s_tdata);
      if (m_tvalid && m_tready)
        board.check_marked(m_tdata, m_tuser);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    int   mode;
    int   stretch;
    int   hold_left;
    int   tick;
    bit   held;
    logic ready;
    m_tready  = 1'b0;
    mode      = 0;
    stretch   = 0;
    hold_left = 0;
    tick      = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      // one long hold-off so the block fills up and stalls its input
      if (!held && board.results >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (stretch == 0) begin
        mode    = $urandom_range(0, 3);
        stretch = $urandom_range(10, 120);
      end
      stretch--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        ready = 1'b0;
      end else begin
        case (mode)
          0:       ready = 1'b1;
          1:       ready = ($urandom_range(0, 3) != 0);
          2:       ready = ($urandom_range(0, 3) == 0);
          default: ready = (tick % 3 != 0);
        endcase
      end
      m_tready <= ready;
    end
  end

  function automatic logic [7:0] rand_printable();
    return 8'($urandom_range(8'h20, 8'h7e));
  endfunction

  task automatic send_byte(logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    prev_byte = b;
    sent_count++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i]);
  endtask

  task automatic crlf();
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic header_line();
    int nlen;
    int vlen;
    nlen = $urandom_range(2, 12);
    vlen = $urandom_range(0, 30);
    repeat (nlen) begin
      if ($urandom_range(0, 1))
        send_byte(8'($urandom_range(8'h41, 8'h5a)));
      else
        send_byte(8'($urandom_range(8'h61, 8'h7a)));
    end
    send_text(": ");
    repeat (vlen) send_byte(rand_printable());
    crlf();
  endtask

  task automatic noise_line();
    logic [7:0] b;
    int         nb;
    nb = $urandom_range(1, 40);
    repeat (nb) begin
      b = 8'($urandom_range(0, 255));
      // CR right after LF would open the blank line that ends the header
      if (prev_byte == CH_LF && b == CH_CR)
        b = 8'h8d;
      send_byte(b);
    end
    if (prev_byte != CH_LF && $urandom_range(0, 1))
      crlf();
    else
      send_byte(CH_LF);
  endtask

  task automatic header_block(int upto);
    int pick;
    while (sent_count < upto) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)
        header_line();
      else if (pick < 9)
        noise_line();
      else
        send_byte(CH_LF);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.marked_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    board.set_reg(idx, val);
  endtask

  task automatic cfg_done();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : main
    string       digits;
    logic [31:0] len_val;
    int          outcome;
    int          n_eff;
    int          budget;
    int          span;
    int          size_cap;
    int          tgt;
    logic        mode_pick;
    logic [4:0]  slots_pick;
    logic [3:0]  tgt_pick;
    board      = new();
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    burst_left = 0;
    sent_count = 0;
    prev_byte  = CH_LF;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    cfg_write(REG_SPLIT_MODE, 5'd0);
    cfg_write(REG_SLOT_COUNT, 5'd0);
    cfg_write(REG_TARGET_SLOT, 5'd15);
    cfg_done();

    // byte extremes, bare LF line, CR CR LF and CR x LF at line start,
    // keyword match restarting on a repeated C
    send_byte(8'h00);
    send_byte(8'hff);
    crlf();
    send_byte(CH_LF);
    send_byte(CH_CR);
    crlf();
    send_text("CContent-Le");
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_text("x");
    send_byte(CH_LF);

    header_block(200);
    drain();
    cfg_write(REG_SLOT_COUNT, 5'd31);
    cfg_write(REG_SPLIT_MODE, 5'd1);
    cfg_write(REG_TARGET_SLOT, 5'd0);
    cfg_done();

    header_block(400);
    drain();
    cfg_write(REG_SLOT_COUNT, 5'd1);
    cfg_write(REG_TARGET_SLOT, 5'd7);
    cfg_done();

    header_block(520);
    drain();

    // final setting, the one the header end samples
    outcome    = $urandom_range(0, 19);
    mode_pick  = 1'($urandom_range(0, 1));
    slots_pick = 5'($urandom_range(0, 31));
    tgt_pick   = 4'($urandom_range(0, 15));
    if (outcome == 4) begin
      mode_pick  = 1'b0;
      slots_pick = 5'($urandom_range(2, 16));
    end
    cfg_write(REG_SPLIT_MODE, {4'd0, mode_pick});
    cfg_write(REG_SLOT_COUNT, slots_pick);
    cfg_write(REG_TARGET_SLOT, {1'b0, tgt_pick});
    cfg_done();

    n_eff = (slots_pick == 0) ? 1 : (slots_pick > MAX_SLOTS) ? MAX_SLOTS : slots_pick;
    tgt   = tgt_pick;
    budget = ITEM_TARGET - sent_count - 150;
    if (budget < 20)
      budget = 20;
    span = $urandom_range(1, budget);
    // keep offset plus size inside the body that is sent
    if (!mode_pick) begin
      size_cap = span / (tgt + 1);
      if (size_cap < 1)
        size_cap = 1;
      len_val = $urandom_range(1, size_cap) * n_eff + $urandom_range(0, n_eff - 1);
    end else begin
      len_val = span;
    end

    case (outcome)
      1: digits = "0";
      2: digits = "none";
      3: begin
        // more than ten digits always saturates
        digits = $sformatf("%0d", $urandom_range(1, 9));
        repeat ($urandom_range(10, 19))
          digits = $sformatf("%s%0d", digits, $urandom_range(0, 9));
      end
      4: digits = $sformatf("%0d", $urandom_range(1, n_eff - 1));
      5: digits = $sformatf("000%0d", len_val);
      default: digits = $sformatf("%0d", len_val);
    endcase

    if (outcome == 0) begin
      header_line();
    end else begin
      send_text("Content-Length");
      if ($urandom_range(0, 3) != 0) begin
        send_text(": ");
      end else begin
        send_byte(rand_printable());
        send_byte(rand_printable());
      end
      send_text(digits);
      if ($urandom_range(0, 3) == 0)
        send_text(" x");
      crlf();
    end
    repeat ($urandom_range(0, 3)) header_line();
    crlf();

    while (sent_count < ITEM_TARGET)
      send_byte(8'($urandom_range(0, 255)));

    drain();
    if (board.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
